>>> rtl/mibs64_block_cipher_assert.svh
// Assertion macros for the MIBS-64 cipher block.
`ifndef MIBS64_BLOCK_CIPHER_ASSERT_SVH
`define MIBS64_BLOCK_CIPHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge out of reset.
`define MIBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Signal must be low on the cycle after a reset edge.
`define MIBS_ASSERT_RST(lbl, clk, rstn, sig, msg) \
    lbl: assert property (@(posedge clk) !rstn |=> !(sig)) else $error(msg);
`else
`define MIBS_ASSERT(lbl, clk, rstn, prop, msg)
`define MIBS_ASSERT_RST(lbl, clk, rstn, sig, msg)
`endif

`endif

>>> rtl/mibs_pkg.sv
`timescale 1ns / 1ps
package mibs_pkg;

    localparam int ROUNDS = 32;
    localparam int RND_W  = 5;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'h4, 4'hF, 4'h3, 4'h8, 4'hD, 4'hA, 4'hC, 4'h0,
        4'hB, 4'h5, 4'h7, 4'hE, 4'h2, 4'h6, 4'h1, 4'h9
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h7, 4'hE, 4'hC, 4'h2, 4'h0, 4'h9, 4'hD, 4'hA,
        4'h3, 4'hF, 4'h5, 4'h8, 4'h6, 4'h4, 4'hB, 4'h1
    };

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] block;
        logic [63:0] key;
    } t_item;

    // Feistel round function on one 32-bit half.
    function automatic logic [31:0] round_fn(input logic [31:0] x, input logic [63:0] key);
        logic [31:0] y;
        logic [31:0] s;
        logic [3:0]  n [8];
        logic [3:0]  m [8];
        y = x ^ key[63:32];
        for (int i = 0; i < 8; i++) begin
            s[4*i +: 4] = SBOX_FWD[y[4*i +: 4]];
        end
        // n[0] is the top nibble
        for (int k = 0; k < 8; k++) begin
            n[k] = s[28 - 4*k +: 4];
        end
        m[0] = n[1] ^ n[2] ^ n[3] ^ n[4] ^ n[5] ^ n[6];
        m[1] = n[0] ^ n[2] ^ n[3] ^ n[5] ^ n[6] ^ n[7];
        m[2] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[6] ^ n[7];
        m[3] = n[0] ^ n[1] ^ n[2] ^ n[4] ^ n[5] ^ n[7];
        m[4] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[5];
        m[5] = n[0] ^ n[1] ^ n[2] ^ n[5] ^ n[6];
        m[6] = n[1] ^ n[2] ^ n[3] ^ n[6] ^ n[7];
        m[7] = n[0] ^ n[2] ^ n[3] ^ n[4] ^ n[7];
        return {m[2], m[0], m[3], m[6], m[7], m[4], m[5], m[1]};
    endfunction

    // Key schedule step, forward direction.
    function automatic logic [63:0] key_fwd(input logic [63:0] key, input logic [RND_W-1:0] rnd);
        logic [63:0] k;
        k = {key[14:0], key[63:15]};
        k[63:60] = SBOX_FWD[k[63:60]];
        k[15:11] = k[15:11] ^ rnd;
        return k;
    endfunction

    // Key schedule step, inverse direction.
    function automatic logic [63:0] key_inv(input logic [63:0] key, input logic [RND_W-1:0] rnd);
        logic [63:0] k;
        k = key;
        k[15:11] = k[15:11] ^ rnd;
        k[63:60] = SBOX_INV[k[63:60]];
        return {k[48:0], k[63:49]};
    endfunction

endpackage

>>> rtl/mibs_cell.sv
`timescale 1ns / 1ps
// One round of the cipher, either direction, with its stage register.
module mibs_cell import mibs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic             i_valid,
    input  t_item            i_item,
    input  logic [RND_W-1:0] i_enc_rnd,
    input  logic [RND_W-1:0] i_dec_rnd,
    output logic             o_valid,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [63:0] w_key_e;
    logic [31:0] w_left;
    logic [31:0] w_right;

    assign w_left  = i_item.block[63:32];
    assign w_right = i_item.block[31:0];
    assign w_key_e = key_fwd(i_item.key, i_enc_rnd);

    always_comb begin
        n_item.cmd = i_item.cmd;
        if (i_item.cmd == CMD_ENCRYPT) begin
            n_item.block = {round_fn(w_left, w_key_e) ^ w_right, w_left};
            n_item.key   = w_key_e;
        end else begin
            n_item.block = {w_right, round_fn(w_right, i_item.key) ^ w_left};
            n_item.key   = key_inv(i_item.key, i_dec_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/mibs64_block_cipher.sv
// MIBS-64 block cipher, 32-round Feistel, one round per pipeline cell.
// Each input block passes through the register of every cell (one register per cell) to the output.
// Throughput: one block per cycle unless stalled; a stalled output lets bubbles in the chain
// collapse, so input transfers continue until every cell holds a block.
// Reset (i_rst_n low, synchronous): clears all cell valid bits; data is not reset.
`timescale 1ns / 1ps
`include "mibs64_block_cipher_assert.svh"
module mibs64_block_cipher import mibs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [63:0] i_block_in,
    input  logic [63:0] i_key_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_block_out,
    output logic [63:0] o_key_out
);

    // Valid and item chain: entry 0 is the input port, entry j+1 is the
    // register of cell j. The last cell register doubles as output register.
    logic  [ROUNDS:0] w_vchain;
    t_item            w_ichain [ROUNDS+1];
    // w_go[j]: cell j loads this cycle. It loads when it is empty or its
    // downstream neighbor loads too, so holes in the chain fill up under stall.
    logic  [ROUNDS:0] w_go;

    assign w_vchain[0]       = i_valid;
    assign w_ichain[0].cmd   = t_cmd'(i_command);
    assign w_ichain[0].block = i_block_in;
    assign w_ichain[0].key   = i_key_in;

    assign w_go[ROUNDS] = !w_vchain[ROUNDS] || !i_stall;

    for (genvar j = 0; j < ROUNDS; j++) begin : g_cell
        // Encryption cell j runs round j+1; decryption runs round ROUNDS-j.
        // Round numbers count modulo 32 (five-bit key field).
        localparam logic [RND_W-1:0] ENC_RND = RND_W'(j + 1);
        localparam logic [RND_W-1:0] DEC_RND = RND_W'(ROUNDS - j);

        assign w_go[j] = !w_vchain[j+1] || w_go[j+1];

        mibs_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_go      (w_go[j]),
            .i_valid   (w_vchain[j]),
            .i_item    (w_ichain[j]),
            .i_enc_rnd (ENC_RND),
            .i_dec_rnd (DEC_RND),
            .o_valid   (w_vchain[j+1]),
            .o_item    (w_ichain[j+1])
        );
    end

    // Input stalls only when every cell holds a block and the output is stalled.
    assign o_stall     = !w_go[0];
    assign o_valid     = w_vchain[ROUNDS];
    assign o_block_out = w_ichain[ROUNDS].block;
    assign o_key_out   = w_ichain[ROUNDS].key;

    logic w_in_xfer;
    logic w_out_xfer;
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = o_valid && !i_stall;

    // ---- checks ----
    `MIBS_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, o_valid, "output valid right after reset")
    `MIBS_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (&w_vchain[ROUNDS:1]), "input stalled with a free cell")
    `MIBS_ASSERT(a_occupancy, i_clk, i_rst_n, $past(i_rst_n) |-> ($countones(w_vchain[ROUNDS:1]) == $past($countones(w_vchain[ROUNDS:1])) + $past(32'(w_in_xfer)) - $past(32'(w_out_xfer))), "block count in chain lost or duplicated")

endmodule
